/* hdl/mqe_pkg.sv */
package mqe_pkg;

  localparam int NUM_CHANNELS = 5;
  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int COUNT_W = 32;
  localparam int TABLE_W = 32;
  localparam logic [TABLE_W-1:0] STEP_TABLE_RESET = 32'd876855580;

  typedef struct packed {
    logic phase_a;
    logic phase_b;
  } in_item_t;

  typedef struct packed {
    logic [2:0]                channel;
    logic signed [COUNT_W-1:0] count;
    logic [2:0]                next_select;
  } out_item_t;

  // One channel update as produced by the channel bank.
  typedef struct packed {
    logic [CH_W-1:0]           ch;
    logic signed [COUNT_W-1:0] count;
    logic [CH_W-1:0]           next_ch;
  } chan_upd_t;

endpackage

/* hdl/mqe_step_lut.sv */
module mqe_step_lut (
  input  logic [mqe_pkg::TABLE_W-1:0]        step_table,
  input  logic [3:0]                         idx,
  output logic signed [mqe_pkg::COUNT_W-1:0] step
);

  logic [1:0] raw;

  always_comb begin
    raw  = step_table[{idx, 1'b0} +: 2];
    step = {{(mqe_pkg::COUNT_W-2){raw[1]}}, raw};
  end

endmodule

/* hdl/mqe_chan_bank.sv */
module mqe_chan_bank (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic [1:0]                  phase_now,
  input  logic [mqe_pkg::TABLE_W-1:0] step_table,
  output mqe_pkg::chan_upd_t          upd
);

  localparam int N = mqe_pkg::NUM_CHANNELS;
  localparam int W = mqe_pkg::CH_W;

  logic [W-1:0]                       ptr_r;
  logic [W-1:0]                       ptr_nxt;
  logic [W-1:0]                       ch;
  logic [1:0]                         last_phase_r [N];
  logic signed [mqe_pkg::COUNT_W-1:0] count_r [N];
  logic signed [mqe_pkg::COUNT_W-1:0] count_nxt;
  logic signed [mqe_pkg::COUNT_W-1:0] step;

  // an out-of-range pointer falls back to channel 0
  always_comb begin
    ch = (ptr_r >= W'(N)) ? '0 : ptr_r;
    ptr_nxt = (ch == W'(N-1)) ? '0 : ch + W'(1);
  end

  mqe_step_lut u_lut (
    .step_table (step_table),
    .idx        ({last_phase_r[ch], phase_now}),
    .step       (step)
  );

  assign count_nxt = count_r[ch] + step;

  always_comb begin
    upd.ch      = ch;
    upd.count   = count_nxt;
    upd.next_ch = ptr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
      for (int i = 0; i < N; i++) begin
        last_phase_r[i] <= '0;
        count_r[i]      <= '0;
      end
    end else if (en) begin
      ptr_r            <= ptr_nxt;
      last_phase_r[ch] <= phase_now;
      count_r[ch]      <= count_nxt;
    end
  end

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r < W'(N))
    else $error("channel pointer out of range");

  a_ptr_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && en) |=> (ptr_r == (($past(ptr_r) == W'(N-1)) ? '0 : $past(ptr_r) + W'(1))))
    else $error("channel pointer did not advance cyclically");

  a_ptr_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !en) |=> $stable(ptr_r))
    else $error("channel pointer moved without a transaction");

endmodule

/* hdl/muxed_quadrature_encoder_scanner_core.sv */
// A transaction accepted at one clock edge is registered and shows on out_* after that edge.
// Throughput: one transaction per cycle while in_stall is low; the step lookup and 32-bit count add on the
// selected channel complete in the same cycle as the read-modify-write of its state.
// in_stall rises only while a held result is stalled downstream.
// Reset (synchronous, rst_n low): counts, last phases and pointer go to zero,
// step_table returns to its reset value, out_valid drops.
module muxed_quadrature_encoder_scanner_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  mqe_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output mqe_pkg::out_item_t          out_data,
  input  logic                        cfg_wr_en,
  input  logic [mqe_pkg::TABLE_W-1:0] cfg_wr_data
);

  logic [mqe_pkg::TABLE_W-1:0] step_table_r;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  mqe_pkg::out_item_t          out_data_r;
  mqe_pkg::out_item_t          out_data_nxt;
  mqe_pkg::chan_upd_t          upd;
  logic                        accept;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_table_r <= mqe_pkg::STEP_TABLE_RESET;
    end else if (cfg_wr_en) begin
      step_table_r <= cfg_wr_data;
    end
  end

  mqe_chan_bank u_bank (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (accept),
    .phase_now  ({in_data.phase_a, in_data.phase_b}),
    .step_table (step_table_r),
    .upd        (upd)
  );

  always_comb begin
    out_valid_nxt            = accept || (out_valid_r && out_stall);
    out_data_nxt.channel     = 3'(upd.ch);
    out_data_nxt.count       = upd.count;
    out_data_nxt.next_select = 3'(upd.next_ch);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_accept_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && accept) |=> out_valid)
    else $error("accepted transaction produced no result");

  a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.channel < 3'(mqe_pkg::NUM_CHANNELS)))
    else $error("result channel out of range");

  a_select_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.channel == 3'(mqe_pkg::NUM_CHANNELS - 1))
      |-> (out_data.next_select == 3'd0))
    else $error("next select did not wrap after last channel");

endmodule

/* tb/tb_muxed_quadrature_encoder_scanner_core.sv */
`timescale 1ns / 1ps

module tb_muxed_quadrature_encoder_scanner_core;

  localparam int HOLD_LEN       = 200;
  localparam int QUIET_LIMIT    = 2000;
  localparam int PHASE_ITEMS    = 185;
  localparam int NUM_PHASES     = 10;
  localparam logic [mqe_pkg::TABLE_W-1:0] TBL_ALL_MINUS2 = 32'hAAAA_AAAA;
  localparam logic [mqe_pkg::TABLE_W-1:0] TBL_ALL_PLUS1  = 32'h5555_5555;
  localparam logic [mqe_pkg::TABLE_W-1:0] TBL_ALL_MINUS1 = 32'hFFFF_FFFF;
  localparam logic [mqe_pkg::TABLE_W-1:0] TBL_ALL_ZERO   = 32'h0000_0000;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  mqe_pkg::in_item_t           in_data;
  logic                        out_valid;
  logic                        out_stall;
  mqe_pkg::out_item_t          out_data;
  logic                        cfg_wr_en;
  logic [mqe_pkg::TABLE_W-1:0] cfg_wr_data;

  muxed_quadrature_encoder_scanner_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Predicted scanner state
  logic [2:0]                         enc_ptr;
  logic [1:0]                         enc_last  [mqe_pkg::NUM_CHANNELS];
  logic signed [mqe_pkg::COUNT_W-1:0] enc_count [mqe_pkg::NUM_CHANNELS];
  logic [mqe_pkg::TABLE_W-1:0]        step_tbl;

  // Stimulus-side shadow, used to build legal gray-code walks per channel
  int         sample_ch;
  logic [1:0] sample_ph [mqe_pkg::NUM_CHANNELS];

  mqe_pkg::in_item_t  sample_q [$];
  mqe_pkg::out_item_t count_q  [$];

  int   errors = 0;
  int   quiet;
  bit   calm;
  logic hold_trig;
  int   hold_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report(input string what);
    errors++;
    $display("ERROR at %0t: %s", $time, what);
  endtask

  function automatic mqe_pkg::out_item_t scan_tick(input mqe_pkg::in_item_t s);
    logic [2:0]         ch;
    logic [1:0]         now;
    logic [3:0]         idx;
    logic [1:0]         raw;
    mqe_pkg::out_item_t r;
    ch  = (enc_ptr >= mqe_pkg::NUM_CHANNELS) ? 3'd0 : enc_ptr;
    now = {s.phase_a, s.phase_b};
    idx = {enc_last[ch], now};
    raw = step_tbl[2*idx +: 2];
    enc_count[ch] = enc_count[ch] + {{30{raw[1]}}, raw};
    enc_last[ch]  = now;
    enc_ptr       = (ch + 1 >= mqe_pkg::NUM_CHANNELS) ? 3'd0 : 3'(ch + 1);
    r.channel     = ch;
    r.count       = enc_count[ch];
    r.next_select = enc_ptr;
    return r;
  endfunction

  task automatic queue_pair(input logic [1:0] pair);
    mqe_pkg::in_item_t s;
    s.phase_a = pair[1];
    s.phase_b = pair[0];
    sample_q.push_back(s);
    sample_ph[sample_ch] = pair;
    sample_ch = (sample_ch + 1 >= mqe_pkg::NUM_CHANNELS) ? 0 : sample_ch + 1;
  endtask

  // Mostly legal quadrature moves (hold, forward, back), some arbitrary jumps
  task automatic load_walk(input int n);
    logic [1:0] pos;
    logic [1:0] pair;
    for (int i = 0; i < n; i++) begin
      pair = sample_ph[sample_ch];
      if ($urandom_range(0, 99) < 85) begin
        pos = {pair[1], pair[1] ^ pair[0]};
        case ($urandom_range(0, 2))
          1: pos = pos + 2'd1;
          2: pos = pos - 2'd1;
          default: ;
        endcase
        pair = pos ^ (pos >> 1);
      end else begin
        pair = 2'($urandom);
      end
      queue_pair(pair);
    end
  endtask

  // checked between edges, once the driver's updates have settled
  task automatic wait_drained();
    while (sample_q.size() != 0 || in_valid || count_q.size() != 0) @(negedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_table(input logic [mqe_pkg::TABLE_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    step_tbl = v;
  endtask

  // Per-channel sequences for the opening part; together they visit all
  // sixteen old/new phase transitions. Slot j of channel c at bits 2j+1:2j.
  function automatic logic [9:0] opening_seq(input int c);
    case (c)
      0: opening_seq = {2'd0, 2'd0, 2'd2, 2'd3, 2'd1};
      1: opening_seq = {2'd3, 2'd0, 2'd1, 2'd3, 2'd2};
      2: opening_seq = {2'd1, 2'd2, 2'd2, 2'd1, 2'd1};
      3: opening_seq = {2'd1, 2'd2, 2'd0, 2'd3, 2'd3};
      default: opening_seq = {2'd2, 2'd1, 2'd3, 2'd0, 2'd2};
    endcase
  endfunction

  // Input driver
  always @(posedge clk) begin : drv
    logic              nv;
    mqe_pkg::in_item_t nd;
    int                gap_left;
    if (rst_n) begin
      nv = in_valid;
      nd = in_data;
      if (in_valid && !in_stall) begin
        count_q.push_back(scan_tick(in_data));
        nv = 1'b0;
        gap_left = (calm || hold_left != 0) ? 0 : $urandom_range(0, 5);
      end
      if (!nv) begin
        if (gap_left == 0 && sample_q.size() != 0) begin
          nd = sample_q.pop_front();
          nv = 1'b1;
        end else if (gap_left > 0) begin
          gap_left--;
        end
      end
      in_valid <= nv;
      in_data  <= nd;
    end else begin
      gap_left = 0;
      enc_ptr  = '0;
      for (int c = 0; c < mqe_pkg::NUM_CHANNELS; c++) begin
        enc_last[c]  = '0;
        enc_count[c] = '0;
      end
      in_valid <= 1'b0;
      in_data  <= '0;
    end
  end

  // Result monitor and receiver stall
  always @(posedge clk) begin : mon
    mqe_pkg::out_item_t want;
    int                 stall_left;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (count_q.size() == 0) begin
          report($sformatf("unexpected result ch %0d count %0d",
                           out_data.channel, out_data.count));
        end else begin
          want = count_q.pop_front();
          if (out_data.channel !== want.channel)
            report($sformatf("channel got %0d want %0d", out_data.channel, want.channel));
          if (out_data.count !== want.count)
            report($sformatf("count ch %0d got %0d want %0d",
                             want.channel, out_data.count, want.count));
          if (out_data.next_select !== want.next_select)
            report($sformatf("next_select got %0d want %0d",
                             out_data.next_select, want.next_select));
        end
        stall_left = calm ? 0 : $urandom_range(0, 5);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0) || (hold_left != 0);
    end else begin
      stall_left = 0;
      out_stall <= 1'b0;
    end
  end

  // Long receiver hold-off, so the block backs up into in_stall
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_trig) begin
      hold_left <= HOLD_LEN;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [mqe_pkg::TABLE_W-1:0] tbl;
    logic [9:0]                  seq;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    hold_trig   = 1'b0;
    calm        = 1'b0;
    step_tbl    = mqe_pkg::STEP_TABLE_RESET;
    sample_ch   = 0;
    for (int c = 0; c < mqe_pkg::NUM_CHANNELS; c++) begin
      sample_ph[c] = '0;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Opening part on the reset table: every transition, pointer wraps
    for (int k = 0; k < 25; k++) begin
      seq = opening_seq(k % 5);
      queue_pair(seq[2*(k/5) +: 2]);
    end
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: tbl = TBL_ALL_MINUS2;
        1: tbl = TBL_ALL_PLUS1;
        2: tbl = TBL_ALL_ZERO;
        3: tbl = TBL_ALL_MINUS1;
        4: tbl = mqe_pkg::STEP_TABLE_RESET;
        default: tbl = $urandom;
      endcase
      write_table(tbl);
      calm = (p == 2 || p == 7);
      load_walk(PHASE_ITEMS);
      if (p == 4) begin
        hold_trig <= 1'b1;
        @(posedge clk);
        hold_trig <= 1'b0;
      end
      wait_drained();
    end

    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
